### sv/tdpf_pkg.sv
// shared constants and types of the trial division prime filter
`default_nettype none
package tdpf_pkg;

    localparam int KEY_DEPTH_DEF   = 2048;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int          APB_ADDR_W      = 3;
    localparam logic        REG_KEY_BOUND   = 1'b0;
    localparam logic [15:0] KEY_BOUND_RESET = 16'd10000;

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_ISSUE  = 4'b0010,
        S_DRAIN  = 4'b0100,
        S_FINISH = 4'b1000
    } t_state;

endpackage
`default_nettype wire

### sv/trial_division_prime_filter_core.sv
// top level of the trial division prime filter: control, key prime table and divider cell row
//
// A candidate is taken when start is high and busy is low; busy stays high until its result
// has been issued. Each candidate of two or more is divided by every stored key prime, one prime
// entering a row of VALUE_WIDTH restoring division cells per cycle from the key prime ram. The
// result appears for exactly one cycle with o_result_strobe and cannot be held off. key_bound is
// written over the apb port at byte address 0; the user is to write it only while idle, which the
// block itself does not enforce.
`default_nettype none
module trial_division_prime_filter_core
    import tdpf_pkg::*;
#(
    parameter int KEY_DEPTH   = KEY_DEPTH_DEF,
    parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  start,
    output logic                 busy,
    input  wire  [31:0]          i_candidate_value,
    output logic                 o_result_strobe,
    output logic [31:0]          o_tested_value,
    output logic                 o_is_prime,
    output logic [31:0]          o_primes_so_far,
    output logic                 o_table_overflow,
    input  wire                  psel,
    input  wire                  penable,
    input  wire                  pwrite,
    input  wire  [APB_ADDR_W-1:0] paddr,
    input  wire  [31:0]          pwdata,
    output logic [31:0]          prdata,
    output logic                 pready
);

    localparam int AW = $clog2(KEY_DEPTH);
    localparam int CW = $clog2(KEY_DEPTH + 1);
    localparam int W  = VALUE_WIDTH;

    t_state          r_state, n_state;
    logic [W-1:0]    r_value;
    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_idx, n_idx;
    logic            r_div;
    logic            r_rd_valid;
    logic [31:0]     r_total, n_total;
    logic [15:0]     r_key_bound;

    logic            r_out_strobe;
    logic [W-1:0]    r_out_value;
    logic            r_out_prime;
    logic [31:0]     r_out_total;
    logic            r_out_ovf;

    logic            accept;
    logic            cfg_write;
    logic [W-1:0]    cand;
    logic            is_prime;
    logic            store_key;
    logic            table_full;
    logic            ram_we;
    logic            ram_re;
    logic [W-1:0]    ram_rdata;
    logic            chain_busy;

    logic [W:0]      c_valid;
    logic [W-1:0]    c_divisor [W+1];
    logic [W-1:0]    c_rem     [W+1];

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready && (paddr[2] == REG_KEY_BOUND);
    assign prdata    = (paddr[2] == REG_KEY_BOUND) ? {16'd0, r_key_bound} : 32'd0;

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign cand   = i_candidate_value[W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_bound <= KEY_BOUND_RESET;
        end else if (cfg_write) begin
            r_key_bound <= pwdata[15:0];
        end
    end

    // prime decision and bookkeeping at the end of a candidate
    always_comb begin
        is_prime   = (r_value >= W'(2)) && !r_div;
        table_full = (r_count >= CW'(KEY_DEPTH));
        store_key  = is_prime && (32'(r_value) <= 32'(r_key_bound));
        ram_we     = (r_state == S_FINISH) && store_key && !table_full;
        ram_re     = (r_state == S_ISSUE);
        chain_busy = r_rd_valid || (|c_valid[W:1]);
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_count = r_count;
        n_total = r_total;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx = '0;
                    if (cand < W'(2) || r_count == '0) begin
                        n_state = S_FINISH;
                    end else begin
                        n_state = S_ISSUE;
                    end
                end
            end
            S_ISSUE: begin
                n_idx = r_idx + CW'(1);
                if (n_idx == r_count) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!chain_busy) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                if (is_prime && r_total != 32'hFFFF_FFFF) begin
                    n_total = r_total + 32'd1;
                end
                if (ram_we) begin
                    n_count = r_count + CW'(1);
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_total      <= '0;
            r_idx        <= '0;
            r_div        <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_out_strobe <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_total      <= n_total;
            r_idx        <= n_idx;
            r_rd_valid   <= ram_re;
            r_out_strobe <= (r_state == S_FINISH);
            if (accept) begin
                r_div <= 1'b0;
            end else if (c_valid[W] && c_rem[W] == '0) begin
                r_div <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_value <= cand;
        end
        if (r_state == S_FINISH) begin
            r_out_value <= r_value;
            r_out_prime <= is_prime;
            r_out_total <= n_total;
            r_out_ovf   <= store_key && table_full;
        end
    end

    tdpf_ram #(
        .WIDTH (W),
        .DEPTH (KEY_DEPTH)
    ) u_key_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_count[AW-1:0]),
        .i_wdata (r_value),
        .i_re    (ram_re),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign c_valid[0]   = r_rd_valid;
    assign c_divisor[0] = ram_rdata;
    assign c_rem[0]     = '0;

    // cell k brings in dividend bit W-1-k
    for (genvar k = 0; k < W; k++) begin : g_cell
        tdpf_div_cell #(
            .WIDTH (W)
        ) u_cell (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_valid   (c_valid[k]),
            .i_divisor (c_divisor[k]),
            .i_rem     (c_rem[k]),
            .i_bit     (r_value[W-1-k]),
            .o_valid   (c_valid[k+1]),
            .o_divisor (c_divisor[k+1]),
            .o_rem     (c_rem[k+1])
        );
    end

    assign o_result_strobe  = r_out_strobe;
    assign o_tested_value   = 32'(r_out_value);
    assign o_is_prime       = r_out_prime;
    assign o_primes_so_far  = r_out_total;
    assign o_table_overflow = r_out_ovf;

endmodule
`default_nettype wire

### sv/tdpf_ram.sv
// generic single write, single read ram with registered read data
`default_nettype none
module tdpf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 2048
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule
`default_nettype wire

### sv/tdpf_div_cell.sv
// one restoring division step cell of the remainder chain
`default_nettype none
module tdpf_div_cell #(
    parameter int WIDTH = 32
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_valid,
    input  wire  [WIDTH-1:0] i_divisor,
    input  wire  [WIDTH-1:0] i_rem,
    input  wire              i_bit,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_divisor,
    output logic [WIDTH-1:0] o_rem
);

    logic [WIDTH:0] shifted;
    logic [WIDTH:0] diff;
    logic           ge;

    always_comb begin
        shifted = {i_rem, i_bit};
        diff    = shifted - {1'b0, i_divisor};
        ge      = shifted >= {1'b0, i_divisor};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else begin
            o_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        o_divisor <= i_divisor;
        o_rem     <= ge ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
    end

endmodule
`default_nettype wire

### sim/testbench.sv
`timescale 1ns / 1ps
// self-checking regression of the trial division prime filter core
module testbench;
    import tdpf_pkg::*;

    localparam int KEY_DEPTH    = KEY_DEPTH_DEF;
    localparam int VALUE_WIDTH  = VALUE_WIDTH_DEF;
    localparam int UNUSED_REG   = 1;
    localparam int DRAIN_CYCLES = KEY_DEPTH + VALUE_WIDTH + 64;

    localparam logic [APB_ADDR_W-1:0] KEY_BOUND_ADDR = APB_ADDR_W'(REG_KEY_BOUND) << 2;
    localparam logic [APB_ADDR_W-1:0] UNUSED_ADDR    = APB_ADDR_W'(UNUSED_REG * 4);
    localparam logic [15:0]           KEY_BOUND_MIN  = 16'd2;
    localparam logic [15:0]           KEY_BOUND_MAX  = 16'hFFFF;
    localparam logic [31:0]           COUNT_MAX      = 32'hFFFF_FFFF;
    localparam logic [31:0]           VALUE_MASK     = 32'((64'd1 << VALUE_WIDTH) - 64'd1);

    typedef struct packed {
        logic [31:0] value;
        logic        prime;
        logic [31:0] count;
        logic        overflow;
    } t_sieve_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [31:0]           i_candidate_value = '0;
    logic                  o_result_strobe;
    logic [31:0]           o_tested_value;
    logic                  o_is_prime;
    logic [31:0]           o_primes_so_far;
    logic                  o_table_overflow;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    t_sieve_result pending_results[$];
    logic [31:0]   key_primes[$];
    logic [31:0]   prime_count = '0;
    logic [15:0]   key_bound = KEY_BOUND_RESET;
    logic [31:0]   next_candidate = 32'd2;
    int            error_count = 0;

    trial_division_prime_filter_core i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .start            (start),
        .busy             (busy),
        .i_candidate_value(i_candidate_value),
        .o_result_strobe  (o_result_strobe),
        .o_tested_value   (o_tested_value),
        .o_is_prime       (o_is_prime),
        .o_primes_so_far  (o_primes_so_far),
        .o_table_overflow (o_table_overflow),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_sieve_result sieve_candidate(input logic [31:0] raw);
        t_sieve_result r;
        logic [31:0]   v;
        logic          divides;
        v = raw & VALUE_MASK;
        divides = 1'b0;
        foreach (key_primes[i]) begin
            if (v % key_primes[i] == 32'd0) divides = 1'b1;
        end
        r.value = v;
        r.prime = (v >= 32'd2) && !divides;
        r.overflow = 1'b0;
        if (r.prime) begin
            if (prime_count != COUNT_MAX) prime_count++;
            if (v <= {16'd0, key_bound}) begin
                if (key_primes.size() < KEY_DEPTH) key_primes.push_back(v);
                else r.overflow = 1'b1;
            end
        end
        r.count = prime_count;
        return r;
    endfunction

    always @(posedge i_clk) begin : check_result
        t_sieve_result exp_r;
        if (i_rst_n && o_result_strobe) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected, actual value %0d",
                         $time, o_tested_value);
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                if (o_tested_value !== exp_r.value) begin
                    $display("%0t: tested_value expected %0d actual %0d",
                             $time, exp_r.value, o_tested_value);
                    error_count++;
                end
                if (o_is_prime !== exp_r.prime) begin
                    $display("%0t: is_prime of %0d expected %0b actual %0b",
                             $time, exp_r.value, exp_r.prime, o_is_prime);
                    error_count++;
                end
                if (o_primes_so_far !== exp_r.count) begin
                    $display("%0t: primes_so_far of %0d expected %0d actual %0d",
                             $time, exp_r.value, exp_r.count, o_primes_so_far);
                    error_count++;
                end
                if (o_table_overflow !== exp_r.overflow) begin
                    $display("%0t: table_overflow of %0d expected %0b actual %0b",
                             $time, exp_r.value, exp_r.overflow, o_table_overflow);
                    error_count++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 16);
        return $urandom_range(40, 200);
    endfunction

    task automatic hold_off(input int cycles);
        @(negedge i_clk);
        start = 1'b0;
        repeat (cycles - 1) @(posedge i_clk);
    endtask

    task automatic send_candidate(input logic [31:0] v, input int gap);
        @(negedge i_clk);
        start = 1'b1;
        i_candidate_value = v;
        do @(posedge i_clk); while (busy);
        pending_results.push_back(sieve_candidate(v));
        if (gap > 0) hold_off(gap);
    endtask

    task automatic wait_idle();
        hold_off(1);
        while (pending_results.size() != 0 || busy) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] data);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = addr;
        pwdata = data;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (addr == KEY_BOUND_ADDR) key_bound = data[15:0];
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic apb_read_check(input logic [APB_ADDR_W-1:0] addr, input logic [31:0] expv);
        @(negedge i_clk);
        psel = 1'b1;
        pwrite = 1'b0;
        penable = 1'b0;
        paddr = addr;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== expv) begin
            $display("%0t: register read at %0d expected %0d actual %0d",
                     $time, addr, expv, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
    endtask

    // mostly an ascending run with random skips, plus noise and out of order values
    task automatic run_random(input int n);
        int          kind;
        int          gap;
        logic [31:0] v;
        for (int i = 0; i < n; i++) begin
            kind = $urandom_range(0, 99);
            if (kind < 78) begin
                next_candidate += ($urandom_range(0, 7) == 0) ? $urandom_range(2, 6) : 1;
                v = next_candidate;
            end else if (kind < 86) begin
                v = $urandom;
            end else if (kind < 90) begin
                v = $urandom_range(0, 1);
            end else if (kind < 95 && key_primes.size() != 0) begin
                v = key_primes[$urandom_range(0, key_primes.size() - 1)];
            end else begin
                v = $urandom_range(2, next_candidate);
            end
            gap = (i % 64 < 16) ? 0 : pick_gap();
            send_candidate(v, gap);
        end
    endtask

    task automatic test_reset_value();
        apb_read_check(KEY_BOUND_ADDR, {16'd0, KEY_BOUND_RESET});
    endtask

    task automatic test_directed();
        logic [31:0] corner[$];
        wait_idle();
        apb_write(KEY_BOUND_ADDR, 32'd10);
        apb_read_check(KEY_BOUND_ADDR, 32'd10);
        for (int v = 2; v <= 12; v++) send_candidate(v, pick_gap());
        next_candidate = 32'd12;
        // square of a prime above the bound, values below two, repeat, out of order,
        // largest 32-bit prime, all ones and alternating bits
        corner = '{32'd121, 32'd0, 32'd1, 32'd7, 32'd4, 32'hFFFF_FFFB,
                   32'hFFFF_FFFF, 32'h5555_5555, 32'h8000_0000};
        foreach (corner[i]) send_candidate(corner[i], pick_gap());
    endtask

    task automatic test_min_bound();
        wait_idle();
        apb_write(KEY_BOUND_ADDR, {16'd0, KEY_BOUND_MIN});
        apb_read_check(KEY_BOUND_ADDR, {16'd0, KEY_BOUND_MIN});
        run_random(60);
    endtask

    task automatic test_max_bound();
        wait_idle();
        apb_write(KEY_BOUND_ADDR, {16'd0, KEY_BOUND_MAX});
        apb_read_check(KEY_BOUND_ADDR, {16'd0, KEY_BOUND_MAX});
        run_random(110);
    endtask

    task automatic test_unused_register();
        wait_idle();
        apb_write(UNUSED_ADDR, $urandom);
        apb_read_check(KEY_BOUND_ADDR, {16'd0, key_bound});
        run_random(10);
    endtask

    task automatic test_random_bound();
        logic [15:0] kb;
        wait_idle();
        kb = 16'($urandom_range(2, 65535));
        // upper data bits are not part of the register
        apb_write(KEY_BOUND_ADDR, {16'($urandom), kb});
        apb_read_check(KEY_BOUND_ADDR, {16'd0, kb});
        run_random(45);
        wait_idle();
        apb_write(KEY_BOUND_ADDR, {16'd0, KEY_BOUND_RESET});
        run_random(45);
    endtask

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;
        test_reset_value();
        test_directed();
        test_min_bound();
        test_max_bound();
        test_unused_register();
        test_random_bound();
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("trial_division_prime_filter_core regression: pass");
        end else begin
            $display("trial_division_prime_filter_core regression: fail");
        end
        $finish;
    end

    initial begin
        #30ms;
        $display("trial_division_prime_filter_core regression: fail");
        $finish;
    end

endmodule
